[design/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block: register
// indexes, the configuration bundle and the job record that the front part
// hands to the back part.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int PATTERN_W = 64;
    localparam int LEN_W     = 4;
    localparam int TOTAL_W   = 16;

    localparam logic [TOTAL_W-1:0] COUNT_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_MATCH_PATTERN   = 2'd0,
        REG_MATCH_LENGTH    = 2'd1,
        REG_REPLACE_PATTERN = 2'd2,
        REG_REPLACE_LENGTH  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] match_pattern;
        logic [LEN_W-1:0]     match_length;
        logic [PATTERN_W-1:0] replace_pattern;
        logic [LEN_W-1:0]     replace_length;
    } cfg_t;

    // One job covers all output beats caused by one input byte.
    // count of zero marks an empty end marker (only ever sent with fin set).
    typedef struct packed {
        logic [PATTERN_W-1:0] bytes;
        logic [LEN_W-1:0]     count;
        logic                 fin;
        logic [TOTAL_W-1:0]   total;
    } job_t;

endpackage

[design/sfr_front.sv]
// ----------------------------------------------------------------------------
// sfr_front
// Window tracker: accepts input bytes, updates the match window and the
// replacement counter, and hands at most one job per byte to the back part.
// ----------------------------------------------------------------------------
module sfr_front #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sfr_pkg::cfg_t      cfg,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    output logic               job_push,
    output sfr_pkg::job_t      job
);

    localparam int FILL_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int WIN_W  = 8 * MAX_PATTERN_BYTES;
    localparam logic [sfr_pkg::LEN_W-1:0] MAX_LEN = sfr_pkg::LEN_W'(MAX_PATTERN_BYTES);

    logic [WIN_W-1:0]            window_reg, window_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [sfr_pkg::TOTAL_W-1:0] counter_reg, counter_next;

    logic [sfr_pkg::LEN_W-1:0]   plen, rlen, fill_ext, fill_inc;
    logic [WIN_W-1:0]            win_ins;
    logic                        same;

    // clamp lengths to their legal range
    always_comb
    begin
        if (cfg.match_length == '0)
            plen = sfr_pkg::LEN_W'(1);
        else if (cfg.match_length > MAX_LEN)
            plen = MAX_LEN;
        else
            plen = cfg.match_length;
        if (cfg.replace_length > MAX_LEN)
            rlen = MAX_LEN;
        else
            rlen = cfg.replace_length;
    end

    assign fill_ext = sfr_pkg::LEN_W'(fill_reg);
    assign fill_inc = fill_ext + sfr_pkg::LEN_W'(1);

    always_comb
    begin
        win_ins = window_reg;
        win_ins[8*fill_reg +: 8] = data_byte;
    end

    always_comb
    begin
        same = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            if (sfr_pkg::LEN_W'(i) < plen &&
                win_ins[8*i +: 8] != cfg.match_pattern[8*i +: 8])
                same = 1'b0;
        end
    end

    always_comb
    begin
        window_next  = win_ins;
        fill_next    = fill_reg;
        counter_next = counter_reg;
        job.bytes    = sfr_pkg::PATTERN_W'(win_ins);
        job.count    = '0;
        job.fin      = final_byte;
        priority if (fill_ext >= plen)
        begin
            // pattern shrank below the held bytes: dump everything unmatched
            job.count = fill_inc;
            fill_next = '0;
        end
        else if (fill_inc == plen)
        begin
            if (same)
            begin
                job.bytes = cfg.replace_pattern;
                job.count = rlen;
                fill_next = '0;
                if (counter_reg != sfr_pkg::COUNT_LIMIT)
                    counter_next = counter_reg + sfr_pkg::TOTAL_W'(1);
            end
            else if (final_byte)
            begin
                job.count = plen;
                fill_next = '0;
            end
            else
            begin
                // emit oldest byte, slide the rest down
                job.count   = sfr_pkg::LEN_W'(1);
                window_next = win_ins >> 8;
                fill_next   = FILL_W'(plen - sfr_pkg::LEN_W'(1));
            end
        end
        else
        begin
            if (final_byte)
            begin
                job.count = fill_inc;
                fill_next = '0;
            end
            else
                fill_next = FILL_W'(fill_inc);
        end
        job.total = counter_next;
        job_push  = accept && (job.count != '0 || final_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            counter_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg    <= fill_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

endmodule

[design/sfr_queue.sv]
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sfr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sfr_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd_en,
    output sfr_pkg::job_t rd_job,
    output logic          rd_valid
);

    sfr_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

[design/sfr_back.sv]
// ----------------------------------------------------------------------------
// sfr_back
// Serializer: walks the head job one byte per beat into the output register.
// ----------------------------------------------------------------------------
module sfr_back #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfr_pkg::job_t               job,
    input  logic                        job_valid,
    output logic                        job_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [7:0]                  out_byte,
    output logic                        byte_valid,
    output logic                        run_last,
    output logic                        stream_end,
    output logic [sfr_pkg::TOTAL_W-1:0] replaced_total
);

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg;
    logic             load, marker, last;

    assign marker  = (job.count == '0);
    assign last    = marker || (sfr_pkg::LEN_W'(idx_reg) + sfr_pkg::LEN_W'(1) == job.count);
    assign load    = job_valid && (!out_valid_reg || pop);
    assign job_pop = load && last;
    assign idx_next = last ? '0 : idx_reg + IDX_W'(1);
    assign empty   = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte       <= marker ? 8'd0 : job.bytes[8*idx_reg +: 8];
            byte_valid     <= !marker;
            run_last       <= last;
            stream_end     <= last && job.fin;
            replaced_total <= job.total;
        end
    end

endmodule

[design/stream_find_and_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming fixed-pattern find and replace over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive data_byte/final_byte and raise push; a beat is taken
//   at a clock edge where push is high and full is low. Set final_byte on the
//   last byte of a stream to flush the window.
//   Result channel: while empty is low the oldest result sits on out_byte,
//   byte_valid, run_last, stream_end and replaced_total; raise pop to take it.
//   Configuration: write registers through cfg_write/cfg_index/cfg_data only
//   while the block is idle. Reset values: match length 1, others zero.
// Timing:
//   The first result of an input beat passes through the job queue and the
//   output register before it reaches the result ports. Each input beat
//   yields at most one job of up to MAX_PATTERN_BYTES result beats; the
//   serializer emits one result beat per cycle while pop is high or the
//   output register is free, so input runs at one byte per cycle as long as
//   each byte yields at most one result. Longer replacements and flushes
//   hold the serializer until done, and the two-entry queue raises full.
// Reset and stall: reset empties the window, queue and output register and
//   clears the replacement count. A stalled receiver holds the current
//   result; the queue absorbs two more jobs before full rises.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [sfr_pkg::PATTERN_W-1:0] cfg_data,
    input  logic [7:0]                    data_byte,
    input  logic                          final_byte,
    input  logic                          push,
    output logic                          full,
    output logic [7:0]                    out_byte,
    output logic                          byte_valid,
    output logic                          run_last,
    output logic                          stream_end,
    output logic [sfr_pkg::TOTAL_W-1:0]   replaced_total,
    output logic                          empty,
    input  logic                          pop
);

    sfr_pkg::cfg_t cfg_reg;
    sfr_pkg::job_t front_job, head_job;
    logic          accept, job_push, job_pop, job_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_pattern   <= '0;
            cfg_reg.match_length    <= sfr_pkg::LEN_W'(1);
            cfg_reg.replace_pattern <= '0;
            cfg_reg.replace_length  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (sfr_pkg::reg_index_t'(cfg_index))
                sfr_pkg::REG_MATCH_PATTERN:
                    cfg_reg.match_pattern <= cfg_data;
                sfr_pkg::REG_MATCH_LENGTH:
                    cfg_reg.match_length <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACE_PATTERN:
                    cfg_reg.replace_pattern <= cfg_data;
                sfr_pkg::REG_REPLACE_LENGTH:
                    cfg_reg.replace_length <= cfg_data[sfr_pkg::LEN_W-1:0];
                default:
                    cfg_reg.match_length <= cfg_reg.match_length;
            endcase
        end
    end

    // Take a beat whenever the queue has room; the front never stalls itself.
    assign accept = push && !full;

    sfr_front #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .data_byte (data_byte),
        .final_byte(final_byte),
        .job_push  (job_push),
        .job       (front_job)
    );

    // Decouple classification from serialization.
    sfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (front_job),
        .full    (full),
        .rd_en   (job_pop),
        .rd_job  (head_job),
        .rd_valid(job_valid)
    );

    sfr_back #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (head_job),
        .job_valid     (job_valid),
        .job_pop       (job_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .run_last      (run_last),
        .stream_end    (stream_end),
        .replaced_total(replaced_total)
    );

endmodule

[design/sfr_checker.sv]
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic [7:0]                  out_byte,
    input logic                        byte_valid,
    input logic                        run_last,
    input logic                        stream_end,
    input logic [sfr_pkg::TOTAL_W-1:0] replaced_total,
    input logic                        empty,
    input logic                        pop
);

    // end of stream always closes the run of its input
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_end) |-> run_last)
        else $error("stream_end without run_last");

    // an empty beat is only the end marker
    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (run_last && stream_end))
        else $error("empty beat that does not end the stream");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (out_byte == 8'd0))
        else $error("end marker carries data");

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(byte_valid) &&
                              $stable(run_last) && $stable(replaced_total)))
        else $error("stalled result changed");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .run_last      (run_last),
    .stream_end    (stream_end),
    .replaced_total(replaced_total),
    .empty         (empty),
    .pop           (pop)
);

[verif/stream_find_and_replace_tb.sv]
// ----------------------------------------------------------------------------
// stream_find_and_replace_tb
// Self-checking bench for the streaming find-and-replace block. A queue-fed
// driver offers stream bytes, a monitor pops result beats, and an in-bench
// edit predictor tracks the match window, the register settings and the
// replacement count to check every popped beat in order.
// ----------------------------------------------------------------------------
module stream_find_and_replace_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One stream byte as offered on the input side.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } stream_item_t;

    // One result beat as predicted.
    typedef struct packed {
        logic [7:0]                  data;
        logic                        valid;
        logic                        last;
        logic                        done;
        logic [sfr_pkg::TOTAL_W-1:0] total;
    } edit_beat_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          cfg_write  = 1'b0;
    logic [1:0]                    cfg_index  = '0;
    logic [sfr_pkg::PATTERN_W-1:0] cfg_data   = '0;
    logic [7:0]                    data_byte  = '0;
    logic                          final_byte = 1'b0;
    logic                          push       = 1'b0;
    logic                          pop        = 1'b0;
    logic                          full;
    logic [7:0]                    out_byte;
    logic                          byte_valid;
    logic                          run_last;
    logic                          stream_end;
    logic [sfr_pkg::TOTAL_W-1:0]   replaced_total;
    logic                          empty;

    stream_find_and_replace dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_byte      (data_byte),
        .final_byte     (final_byte),
        .push           (push),
        .full           (full),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .run_last       (run_last),
        .stream_end     (stream_end),
        .replaced_total (replaced_total),
        .empty          (empty),
        .pop            (pop)
    );

    // 4 ns clock: high half, then low half.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the registers, the window of
    // unresolved bytes and the saturating replacement count.
    // ------------------------------------------------------------------------
    logic [sfr_pkg::PATTERN_W-1:0] find_bytes  = '0;
    logic [sfr_pkg::LEN_W-1:0]     find_len    = 4'd1;
    logic [sfr_pkg::PATTERN_W-1:0] subst_bytes = '0;
    logic [sfr_pkg::LEN_W-1:0]     subst_len   = '0;

    logic [7:0]                  window_q [8];
    int unsigned                 window_count = 0;
    logic [sfr_pkg::TOTAL_W-1:0] hits_seen    = '0;

    stream_item_t item_q [$];   // bytes waiting to be offered
    edit_beat_t   edit_q [$];   // result beats still owed by the block

    int  err_count    = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    bit  holdoff_arm  = 1'b0;
    bit  rx_hold      = 1'b0;
    bit  send_gaps    = 1'b0;
    bit  take_gaps    = 1'b0;

    // Effective pattern length: zero counts as one, anything above eight as eight.
    function automatic int unsigned find_span();
        if (find_len == 0)
            return 1;
        return (find_len > 8) ? 8 : find_len;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Work out the beats that one accepted stream byte causes and queue them.
    function automatic void predict_edits(input logic [7:0] b, input logic fin);
        int unsigned plen;
        int unsigned rlen;
        int unsigned fill;
        logic        hit;
        logic [8:0]  outs [$];   // {valid, byte}
        edit_beat_t  e;

        plen = find_span();
        rlen = (subst_len > 8) ? 8 : subst_len;
        fill = window_count;

        if (fill >= plen)
        begin
            // Pattern shrank under a fuller window: release everything unmatched.
            for (int i = 0; i < fill; i++)
                outs.push_back({1'b1, window_q[i]});
            outs.push_back({1'b1, b});
            fill = 0;
        end
        else
        begin
            window_q[fill] = b;
            fill++;
            if (fill == plen)
            begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (window_q[i] != find_bytes[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int i = 0; i < rlen; i++)
                        outs.push_back({1'b1, subst_bytes[8*i +: 8]});
                    if (hits_seen != sfr_pkg::COUNT_LIMIT)
                        hits_seen++;
                    fill = 0;
                end
                else
                begin
                    // Release the oldest byte and slide the rest down.
                    outs.push_back({1'b1, window_q[0]});
                    for (int i = 1; i < fill; i++)
                        window_q[i-1] = window_q[i];
                    fill--;
                end
            end
        end

        if (fin)
        begin
            // Flush the partial window; an empty flush still owes an end marker.
            for (int i = 0; i < fill; i++)
                outs.push_back({1'b1, window_q[i]});
            fill = 0;
            if (outs.size() == 0)
                outs.push_back(9'h000);
        end
        window_count = fill;

        foreach (outs[i])
        begin
            e.data  = outs[i][7:0];
            e.valid = outs[i][8];
            e.last  = (i == outs.size() - 1);
            e.done  = e.last & fin;
            e.total = hits_seen;
            edit_q.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued bytes, hold a byte while full is high, and insert
    // random gaps when enabled.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        stream_item_t next_item;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                predict_edits(data_byte, final_byte);
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (item_q.size() != 0)
                begin
                    next_item = item_q.pop_front();
                    data_byte  <= next_item.data;
                    final_byte <= next_item.fin;
                    push       <= 1'b1;
                    if (send_gaps)
                        send_gap = pick_gap();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off: once armed, keep the receiver away for a counted
    // stretch of cycles.
    // ------------------------------------------------------------------------
    initial
    begin
        wait (holdoff_arm);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (200) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: check each popped beat against the oldest expectation, then
    // decide whether to take the next one.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        edit_beat_t want;
        edit_beat_t got;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got = '{data: out_byte, valid: byte_valid, last: run_last,
                        done: stream_end, total: replaced_total};
                if (edit_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("MISMATCH unexpected: byte=%h vld=%b last=%b end=%b total=%0d",
                                 got.data, got.valid, got.last, got.done, got.total);
                end
                else
                begin
                    want = edit_q.pop_front();
                    if (got !== want)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("MISMATCH exp: byte=%h vld=%b last=%b end=%b total=%0d",
                                     want.data, want.valid, want.last, want.done, want.total);
                            $display("         got: byte=%h vld=%b last=%b end=%b total=%0d",
                                     got.data, got.valid, got.last, got.done, got.total);
                        end
                    end
                end
            end
            if (rx_hold)
            begin
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (take_gaps)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_item(input logic [7:0] b, input logic fin);
        item_q.push_back('{data: b, fin: fin});
    endfunction

    // Write one register and mirror it into the predictor. Call only when idle.
    task automatic write_reg(input sfr_pkg::reg_index_t idx,
                             input logic [sfr_pkg::PATTERN_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            sfr_pkg::REG_MATCH_PATTERN:   find_bytes  = value;
            sfr_pkg::REG_MATCH_LENGTH:    find_len    = value[sfr_pkg::LEN_W-1:0];
            sfr_pkg::REG_REPLACE_PATTERN: subst_bytes = value;
            sfr_pkg::REG_REPLACE_LENGTH:  subst_len   = value[sfr_pkg::LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every byte is taken and every owed beat has been popped,
    // then let the pipeline settle in case the last bytes produced nothing.
    task automatic wait_idle();
        while (item_q.size() != 0 || push || edit_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Length pick: mostly legal, with the extremes and out-of-range codes mixed in.
    function automatic logic [sfr_pkg::PATTERN_W-1:0] pick_len(input int unsigned lo);
        case ($urandom_range(0, 9))
            7:       return 64'd8;
            8:       return 64'(lo);
            9:       return 64'($urandom_range(0, 15));
            default: return 64'($urandom_range(lo, 8));
        endcase
    endfunction

    // Pattern bytes: either fully random or drawn from a two-letter alphabet
    // so that near misses and repeated prefixes are common.
    function automatic logic [sfr_pkg::PATTERN_W-1:0] pick_bytes();
        logic [sfr_pkg::PATTERN_W-1:0] v;
        if ($urandom_range(0, 1) == 0)
            return {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
            v[8*i +: 8] = ($urandom_range(0, 1) == 0) ? 8'h61 : 8'h62;
        return v;
    endfunction

    task automatic pick_config();
        write_reg(sfr_pkg::REG_MATCH_PATTERN, pick_bytes());
        write_reg(sfr_pkg::REG_MATCH_LENGTH, pick_len(1));
        write_reg(sfr_pkg::REG_REPLACE_PATTERN, {$urandom, $urandom});
        write_reg(sfr_pkg::REG_REPLACE_LENGTH, pick_len(0));
    endtask

    // Build a stream biased toward the current pattern: whole matches,
    // prefixes broken by one wrong byte, pattern bytes out of order, noise.
    function automatic void queue_stream(input int count, input bit close);
        int unsigned plen;
        int unsigned cut;
        int          k;
        plen = find_span();
        k = 0;
        while (k < count)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    for (int j = 0; j < plen && k < count; j++, k++)
                        add_item(find_bytes[8*j +: 8], $urandom_range(0, 11) == 0);
                end
                2:
                begin
                    cut = $urandom_range(0, plen - 1);
                    for (int j = 0; j < cut && k < count; j++, k++)
                        add_item(find_bytes[8*j +: 8], $urandom_range(0, 11) == 0);
                    if (k < count)
                    begin
                        add_item(find_bytes[8*cut +: 8] ^ 8'($urandom_range(1, 255)),
                                 $urandom_range(0, 11) == 0);
                        k++;
                    end
                end
                3:
                begin
                    add_item(find_bytes[8*$urandom_range(0, 7) +: 8],
                             $urandom_range(0, 11) == 0);
                    k++;
                end
                default:
                begin
                    add_item(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
                    k++;
                end
            endcase
        end
        // Close the stream, or leave it open so the next setting meets a
        // partly filled window.
        if (close)
            item_q[item_q.size() - 1].fin = 1'b1;
    endfunction

    task automatic run_phase(input int count, input bit close, input bit gaps_on);
        @(negedge clk);
        send_gaps = gaps_on;
        take_gaps = gaps_on;
        queue_stream(count, close);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: pattern 00, length 1, delete. A matched final byte
        // leaves nothing to emit, so an end marker must appear.
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h00, 1'b1);
        wait_idle();

        // Three-byte pattern grown into a full eight-byte all-ones
        // replacement; then a broken prefix flushed at stream end.
        write_reg(sfr_pkg::REG_MATCH_PATTERN, 64'h0000_0000_0063_6261);
        write_reg(sfr_pkg::REG_MATCH_LENGTH, 64'd3);
        write_reg(sfr_pkg::REG_REPLACE_PATTERN, '1);
        write_reg(sfr_pkg::REG_REPLACE_LENGTH, 64'd8);
        @(negedge clk);
        add_item(8'h61, 1'b0);
        add_item(8'h62, 1'b0);
        add_item(8'h63, 1'b0);
        add_item(8'h78, 1'b0);
        add_item(8'h61, 1'b0);
        add_item(8'h62, 1'b1);
        wait_idle();

        // Over-range lengths saturate to eight. Match eight FF bytes, then
        // leave seven bytes sitting in the window with the stream open.
        write_reg(sfr_pkg::REG_MATCH_PATTERN, '1);
        write_reg(sfr_pkg::REG_MATCH_LENGTH, 64'd15);
        write_reg(sfr_pkg::REG_REPLACE_PATTERN, '0);
        write_reg(sfr_pkg::REG_REPLACE_LENGTH, 64'd15);
        @(negedge clk);
        repeat (8) add_item(8'hFF, 1'b0);
        repeat (7) add_item(8'h00, 1'b0);
        wait_idle();

        // Shrink the pattern under the held window: next byte releases all.
        write_reg(sfr_pkg::REG_MATCH_LENGTH, 64'd2);
        @(negedge clk);
        add_item(8'h11, 1'b1);
        wait_idle();

        // Pattern length zero behaves as one.
        write_reg(sfr_pkg::REG_MATCH_LENGTH, 64'd0);
        @(negedge clk);
        add_item(8'hFF, 1'b1);
        wait_idle();

        // Random phases, each ending with the sender paused until drained.
        for (int ph = 0; ph < 10; ph++)
        begin
            pick_config();
            if (ph == 3)
            begin
                // Back up the block: heavy replacements, a long receiver
                // hold-off and a sender that never pauses.
                write_reg(sfr_pkg::REG_MATCH_LENGTH, 64'd1);
                write_reg(sfr_pkg::REG_REPLACE_LENGTH, 64'd8);
                @(negedge clk);
                holdoff_arm = 1'b1;
                run_phase(28, 1'b1, 1'b0);
            end
            else
            begin
                run_phase(28, $urandom_range(0, 3) != 0, (ph % 4) != 1);
            end
        end

        repeat (10) @(posedge clk);
        if (err_count == 0 && edit_q.size() == 0)
            $display("stream_find_and_replace_tb passed");
        else
            $display("stream_find_and_replace_tb failed");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("stream_find_and_replace_tb failed");
        $finish;
    end

endmodule
